// ===== design/dmt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the dirty rectangle merge table.
// Used by dmt_rect_mem, dmt_geom_unit and dirty_rect_merge_table_core; depends on nothing.
package dmt_pkg;

   localparam int MAX_ENTRIES = 8;
   localparam int COORD_BITS  = 10;
   localparam int IN_BITS     = 12;
   localparam int DIM_BITS    = 11;
   localparam int GAP_BITS    = 8;
   localparam int STATUS_BITS = 3;
   localparam int INDEX_BITS  = 3;
   localparam int USED_BITS   = 4;
   localparam int OP_BITS     = 2;

   localparam int IDX_BITS  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
   localparam int BOX_BITS  = (COORD_BITS + 1 > IN_BITS) ? COORD_BITS + 1 : IN_BITS;
   localparam int AREA_BITS = 2 * (COORD_BITS + 1);

   localparam int REQ_DATA_BITS = 4 * IN_BITS;
   localparam int RSP_FIELD_BITS = INDEX_BITS + 4 * COORD_BITS + USED_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = DIM_BITS'(412);
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(412);
   localparam logic [GAP_BITS-1:0] MERGE_GAP_RESET     = GAP_BITS'(8);

   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_MERGE_GAP     = 2'd2
   } reg_index_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_DUMP  = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_REJECTED = 3'd0,
      ST_MERGED   = 3'd1,
      ST_APPENDED = 3'd2,
      ST_FORCED   = 3'd3,
      ST_CLEARED  = 3'd4,
      ST_ENTRY    = 3'd5,
      ST_EMPTY    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      GEOM_CLIP,
      GEOM_GROW_CLIP,
      GEOM_NEAR,
      GEOM_AREA
   } geom_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLEAR,
      S_DUMP_START,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_ADD_CHECK,
      S_ADD_CLIP,
      S_SCAN_RD,
      S_SCAN_OP,
      S_SCAN_CHK,
      S_MERGE_OP,
      S_MERGE_WR,
      S_APPEND,
      S_AREA_RD,
      S_AREA_OP,
      S_AREA_CHK,
      S_BEST_RD,
      S_BEST_OP,
      S_FORCE_WR
   } state_type;

   // Stored entry: clipped, so every corner is a plain screen coordinate.
   typedef struct packed {
      logic [COORD_BITS-1:0] y2;
      logic [COORD_BITS-1:0] x2;
      logic [COORD_BITS-1:0] y1;
      logic [COORD_BITS-1:0] x1;
   } rect_type;

   // Working rectangle with signed corners wide enough for raw input and entries.
   typedef struct packed {
      logic signed [BOX_BITS-1:0] y2;
      logic signed [BOX_BITS-1:0] x2;
      logic signed [BOX_BITS-1:0] y1;
      logic signed [BOX_BITS-1:0] x1;
   } box_type;

   typedef struct packed {
      logic                we;
      logic [IDX_BITS-1:0] waddr;
      logic [IDX_BITS-1:0] raddr;
      rect_type            wdata;
   } mem_req_type;

   typedef struct packed {
      geom_op_type           op;
      rect_type              ent;
      box_type               cand;
      logic [COORD_BITS-1:0] x_max;
      logic [COORD_BITS-1:0] y_max;
      logic [GAP_BITS-1:0]   gap;
   } geom_cmd_type;

   typedef struct packed {
      rect_type             rect;
      logic                 hit;
      logic [AREA_BITS-1:0] area;
   } geom_result_type;

   typedef struct packed {
      status_type            status;
      logic [INDEX_BITS-1:0] index;
      rect_type              rect;
      logic [USED_BITS-1:0]  used;
      logic                  last;
   } rsp_item_type;

   // Largest usable coordinate for a screen dimension: 0 acts as 1, and
   // anything above the coordinate range acts as the full range.
   function automatic logic [COORD_BITS-1:0] dim_to_max(input logic [DIM_BITS-1:0] dim);
      logic [COORD_BITS-1:0] res;
      if (dim == '0) begin
         res = '0;
      end else if (32'(dim) > (32'd1 << COORD_BITS)) begin
         res = '1;
      end else begin
         res = COORD_BITS'(dim - DIM_BITS'(1));
      end
      return res;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic signed [BOX_BITS-1:0] v,
      input logic [COORD_BITS-1:0]      hi
   );
      logic signed [BOX_BITS-1:0] hi_s;
      logic [COORD_BITS-1:0]      res;
      hi_s = BOX_BITS'(hi);
      if (v < 0) begin
         res = '0;
      end else if (v > hi_s) begin
         res = hi;
      end else begin
         res = v[COORD_BITS-1:0];
      end
      return res;
   endfunction

   function automatic box_type rect_to_box(input rect_type r);
      box_type b;
      b.x1 = BOX_BITS'(r.x1);
      b.y1 = BOX_BITS'(r.y1);
      b.x2 = BOX_BITS'(r.x2);
      b.y2 = BOX_BITS'(r.y2);
      return b;
   endfunction

endpackage

// ===== design/dmt_rect_mem.sv =====
`timescale 1ns / 1ps
// Rectangle store of the merge table: one write port and one registered read port.
// Depends on dmt_pkg for the entry and request types.
module dmt_rect_mem (
   input  logic                 clock,
   input  dmt_pkg::mem_req_type mem_req,
   output dmt_pkg::rect_type    rd_data_ff
);
   import dmt_pkg::*;

   rect_type mem_ff [MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.raddr];
   end

endmodule

// ===== design/dmt_geom_unit.sv =====
`timescale 1ns / 1ps
// Shared rectangle unit: clip, grow and clip, proximity test, or pixel count,
// one operation per cycle with a registered result. Depends on dmt_pkg.
module dmt_geom_unit (
   input  logic                     clock,
   input  dmt_pkg::geom_cmd_type    cmd,
   output dmt_pkg::geom_result_type result_ff
);
   import dmt_pkg::*;

   box_type                ent_box;
   box_type                src;
   logic [COORD_BITS-1:0]  x1_cl;
   logic [COORD_BITS-1:0]  x2_cl;
   logic [COORD_BITS-1:0]  x2_up;
   rect_type               clipped;
   rect_type               cand_rect;
   logic [COORD_BITS:0]    gap_ext;
   logic                   hit;
   logic [COORD_BITS:0]    width;
   logic [COORD_BITS:0]    height;
   geom_result_type        result_in;

   always_comb begin
      ent_box = rect_to_box(cmd.ent);
      src     = cmd.cand;
      if (cmd.op == GEOM_GROW_CLIP) begin
         src = ent_box;
         if (cmd.cand.x1 < ent_box.x1) src.x1 = cmd.cand.x1;
         if (cmd.cand.y1 < ent_box.y1) src.y1 = cmd.cand.y1;
         if (cmd.cand.x2 > ent_box.x2) src.x2 = cmd.cand.x2;
         if (cmd.cand.y2 > ent_box.y2) src.y2 = cmd.cand.y2;
      end

      // Clamp to the screen, then widen x to 4-pixel alignment.
      x1_cl      = clamp_coord(src.x1, cmd.x_max);
      x2_cl      = clamp_coord(src.x2, cmd.x_max);
      x2_up      = {x2_cl[COORD_BITS-1:2], 2'b11};
      clipped.x1 = {x1_cl[COORD_BITS-1:2], 2'b00};
      clipped.y1 = clamp_coord(src.y1, cmd.y_max);
      clipped.x2 = (x2_up > cmd.x_max) ? cmd.x_max : x2_up;
      clipped.y2 = clamp_coord(src.y2, cmd.y_max);

      // Candidate is already clipped when it is tested, so its low bits are the coordinate.
      cand_rect.x1 = cmd.cand.x1[COORD_BITS-1:0];
      cand_rect.y1 = cmd.cand.y1[COORD_BITS-1:0];
      cand_rect.x2 = cmd.cand.x2[COORD_BITS-1:0];
      cand_rect.y2 = cmd.cand.y2[COORD_BITS-1:0];
      gap_ext      = (COORD_BITS + 1)'(cmd.gap);
      hit = ({1'b0, cmd.ent.x1} <= {1'b0, cand_rect.x2} + gap_ext) &&
            ({1'b0, cmd.ent.x2} + gap_ext >= {1'b0, cand_rect.x1}) &&
            ({1'b0, cmd.ent.y1} <= {1'b0, cand_rect.y2} + gap_ext) &&
            ({1'b0, cmd.ent.y2} + gap_ext >= {1'b0, cand_rect.y1});

      width  = {1'b0, cmd.ent.x2} - {1'b0, cmd.ent.x1} + (COORD_BITS + 1)'(1);
      height = {1'b0, cmd.ent.y2} - {1'b0, cmd.ent.y1} + (COORD_BITS + 1)'(1);

      result_in = '0;
      case (cmd.op) inside
         GEOM_CLIP, GEOM_GROW_CLIP: result_in.rect = clipped;
         GEOM_NEAR:                 result_in.hit  = hit;
         GEOM_AREA:                 result_in.area = AREA_BITS'(width) * AREA_BITS'(height);
         default:                   result_in      = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

// ===== design/dirty_rect_merge_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the dirty rectangle merge table: sequencer, entry count, CSRs and
// result register. Depends on dmt_pkg, dmt_rect_mem and dmt_geom_unit.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | tvalid / tready    | tuser operation, tdata rectangle corners
//   rsp     | out       | tvalid / tready    | tuser status, tdata entry fields, tlast
//   csr     | in/out    | psel/penable/pready| APB registers at 0x0, 0x4, 0x8
//
// The block takes one item at a time and is ready only when its sequencer is idle.
// A valid add clips the rectangle, then scans the stored entries in index order and
// merges into the first one near enough, else appends. A forced merge on a full
// table scans every entry, then reckons the area of each, then grows the smallest.
// A dump reads and emits the entries in turn. Every entry visit costs one memory
// read, one pass through the shared geometry unit and one decision step.
// Reset clears the entry count, the CSRs and the sequencer; the rectangle store
// is not cleared, since entries at or beyond the count are never read.
// A stalled result holds the sequencer in its emitting state; the next item is
// accepted as soon as the sequencer returns to idle, even if the last result waits.
module dirty_rect_merge_table_core (
   input  logic                               clock,
   input  logic                               reset,
   // Input item.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dmt_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // in_x1, in_y1, in_x2, in_y2
   input  logic [dmt_pkg::OP_BITS-1:0]        req_tuser,  // operation
   // Result item.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dmt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // entry_index, out_x1, out_y1,
                                                          // out_x2, out_y2, entries_used
   output logic [dmt_pkg::STATUS_BITS-1:0]    rsp_tuser,  // status
   output logic                               rsp_tlast,
   // Configuration registers.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dmt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [dmt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [dmt_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import dmt_pkg::*;

   // Sequencer and datapath registers.
   state_type              state_ff, state_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [IDX_BITS-1:0]    best_idx_ff, best_idx_in;
   logic [AREA_BITS-1:0]   best_area_ff, best_area_in;
   box_type                cand_ff, cand_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;

   // Configuration registers.
   logic [DIM_BITS-1:0]    width_ff;
   logic [DIM_BITS-1:0]    height_ff;
   logic [GAP_BITS-1:0]    gap_ff;

   // Result register.
   logic                   rsp_valid_ff;
   rsp_item_type           rsp_item_ff;

   // Interconnect.
   mem_req_type            mem_req;
   rect_type               rd_data;
   geom_cmd_type           geom_cmd;
   geom_result_type        geom_res;
   rsp_item_type           emit_item;
   logic                   emit;
   logic                   out_free;
   logic                   req_fire;
   logic                   csr_write;
   reg_index_type          csr_index;
   logic                   cand_reject;
   logic                   last_idx;
   logic                   table_full;
   state_type              no_hit_state;
   box_type                req_box;

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign table_full = (count_ff >= CNT_BITS'(MAX_ENTRIES));
   assign last_idx   = ((CNT_BITS'(idx_ff) + CNT_BITS'(1)) == count_ff);
   assign cand_reject = (cand_ff.x1 > cand_ff.x2) || (cand_ff.y1 > cand_ff.y2);
   // Without a nearby entry the rectangle is appended, or forced into the smallest one.
   assign no_hit_state = table_full ? S_AREA_RD : S_APPEND;

   // Raw corners, sign extended to the working width.
   assign req_box.x1 = BOX_BITS'($signed(req_tdata[IN_BITS-1:0]));
   assign req_box.y1 = BOX_BITS'($signed(req_tdata[2*IN_BITS-1:IN_BITS]));
   assign req_box.x2 = BOX_BITS'($signed(req_tdata[3*IN_BITS-1:2*IN_BITS]));
   assign req_box.y2 = BOX_BITS'($signed(req_tdata[4*IN_BITS-1:3*IN_BITS]));

   dmt_rect_mem u_rect_mem (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data)
   );

   dmt_geom_unit u_geom_unit (
      .clock     (clock),
      .cmd       (geom_cmd),
      .result_ff (geom_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_tuser))
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_ADD:   state_in = S_ADD_CHECK;
                  OP_DUMP:  state_in = S_DUMP_START;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            if (out_free) state_in = S_IDLE;
         end
         S_DUMP_START: begin
            if (count_ff != '0) begin
               state_in = S_DUMP_RD;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_DUMP_RD: state_in = S_DUMP_OUT;
         S_DUMP_OUT: begin
            if (out_free) state_in = last_idx ? S_IDLE : S_DUMP_RD;
         end
         S_ADD_CHECK: begin
            if (!cand_reject) begin
               state_in = S_ADD_CLIP;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_ADD_CLIP: state_in = (count_ff == '0) ? no_hit_state : S_SCAN_RD;
         S_SCAN_RD:  state_in = S_SCAN_OP;
         S_SCAN_OP:  state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (geom_res.hit) begin
               state_in = S_MERGE_OP;
            end else if (last_idx) begin
               state_in = no_hit_state;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_MERGE_OP: state_in = S_MERGE_WR;
         S_MERGE_WR: begin
            if (out_free) state_in = S_IDLE;
         end
         S_APPEND: begin
            if (out_free) state_in = S_IDLE;
         end
         S_AREA_RD: state_in = S_AREA_OP;
         S_AREA_OP: state_in = S_AREA_CHK;
         S_AREA_CHK: begin
            state_in = (idx_ff == IDX_BITS'(MAX_ENTRIES - 1)) ? S_BEST_RD : S_AREA_RD;
         end
         S_BEST_RD: state_in = S_BEST_OP;
         S_BEST_OP: state_in = S_FORCE_WR;
         S_FORCE_WR: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: memory port, geometry command, emitted result and
   // datapath register updates.
   always_comb begin
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      best_area_in = best_area_ff;
      cand_in      = cand_ff;
      count_in     = count_ff;

      mem_req       = '0;
      mem_req.raddr = idx_ff;

      geom_cmd       = '0;
      geom_cmd.op    = GEOM_NEAR;
      geom_cmd.ent   = rd_data;
      geom_cmd.cand  = cand_ff;
      geom_cmd.x_max = dim_to_max(width_ff);
      geom_cmd.y_max = dim_to_max(height_ff);
      geom_cmd.gap   = gap_ff;

      emit           = 1'b0;
      emit_item      = '0;
      emit_item.used = USED_BITS'(count_ff);
      emit_item.last = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) cand_in = req_box;
         end
         S_CLEAR: begin
            emit_item.status = ST_CLEARED;
            emit_item.used   = '0;
            if (out_free) begin
               emit     = 1'b1;
               count_in = '0;
            end
         end
         S_DUMP_START: begin
            idx_in           = '0;
            emit_item.status = ST_EMPTY;
            emit             = (count_ff == '0) && out_free;
         end
         S_DUMP_RD: begin
         end
         S_DUMP_OUT: begin
            emit_item.status = ST_ENTRY;
            emit_item.index  = INDEX_BITS'(idx_ff);
            emit_item.rect   = rd_data;
            emit_item.last   = last_idx;
            if (out_free) begin
               emit   = 1'b1;
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
         S_ADD_CHECK: begin
            geom_cmd.op      = GEOM_CLIP;
            emit_item.status = ST_REJECTED;
            emit             = cand_reject && out_free;
         end
         S_ADD_CLIP: begin
            cand_in      = rect_to_box(geom_res.rect);
            idx_in       = '0;
            best_area_in = '1;
            best_idx_in  = '0;
         end
         S_SCAN_RD: begin
         end
         S_SCAN_OP: begin
         end
         S_SCAN_CHK: begin
            if (!geom_res.hit) begin
               idx_in = last_idx ? '0 : idx_ff + IDX_BITS'(1);
            end
         end
         S_MERGE_OP: begin
            geom_cmd.op = GEOM_GROW_CLIP;
         end
         S_MERGE_WR: begin
            geom_cmd.op      = GEOM_GROW_CLIP;
            emit_item.status = ST_MERGED;
            emit_item.index  = INDEX_BITS'(idx_ff);
            emit_item.rect   = geom_res.rect;
            mem_req.waddr    = idx_ff;
            mem_req.wdata    = geom_res.rect;
            if (out_free) begin
               emit       = 1'b1;
               mem_req.we = 1'b1;
            end
         end
         S_APPEND: begin
            emit_item.status = ST_APPENDED;
            emit_item.index  = INDEX_BITS'(count_ff);
            emit_item.rect   = geom_res.rect;
            emit_item.used   = USED_BITS'(count_ff + CNT_BITS'(1));
            mem_req.waddr    = count_ff[IDX_BITS-1:0];
            mem_req.wdata.x1 = cand_ff.x1[COORD_BITS-1:0];
            mem_req.wdata.y1 = cand_ff.y1[COORD_BITS-1:0];
            mem_req.wdata.x2 = cand_ff.x2[COORD_BITS-1:0];
            mem_req.wdata.y2 = cand_ff.y2[COORD_BITS-1:0];
            emit_item.rect   = mem_req.wdata;
            if (out_free) begin
               emit       = 1'b1;
               mem_req.we = 1'b1;
               count_in   = count_ff + CNT_BITS'(1);
            end
         end
         S_AREA_RD: begin
         end
         S_AREA_OP: begin
            geom_cmd.op = GEOM_AREA;
         end
         S_AREA_CHK: begin
            // Strictly smaller wins, so the lowest index keeps a tie.
            if (geom_res.area < best_area_ff) begin
               best_area_in = geom_res.area;
               best_idx_in  = idx_ff;
            end
            idx_in = idx_ff + IDX_BITS'(1);
         end
         S_BEST_RD: begin
            mem_req.raddr = best_idx_ff;
         end
         S_BEST_OP: begin
            mem_req.raddr = best_idx_ff;
            geom_cmd.op   = GEOM_GROW_CLIP;
         end
         S_FORCE_WR: begin
            mem_req.raddr    = best_idx_ff;
            geom_cmd.op      = GEOM_GROW_CLIP;
            emit_item.status = ST_FORCED;
            emit_item.index  = INDEX_BITS'(best_idx_ff);
            emit_item.rect   = geom_res.rect;
            mem_req.waddr    = best_idx_ff;
            mem_req.wdata    = geom_res.rect;
            if (out_free) begin
               emit       = 1'b1;
               mem_req.we = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      best_idx_ff  <= best_idx_in;
      best_area_ff <= best_area_in;
      cand_ff      <= cand_in;
      if (emit) rsp_item_ff <= emit_item;
   end

   // Result channel.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.status;
   assign rsp_tlast  = rsp_item_ff.last;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_item_ff.used,
                                       rsp_item_ff.rect.y2, rsp_item_ff.rect.x2,
                                       rsp_item_ff.rect.y1, rsp_item_ff.rect.x1,
                                       rsp_item_ff.index});

   // Configuration registers. Writes to addresses past the list are dropped.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
         gap_ff    <= MERGE_GAP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  width_ff  <= csr_pwdata[DIM_BITS-1:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_pwdata[DIM_BITS-1:0];
            REG_MERGE_GAP:     gap_ff    <= csr_pwdata[GAP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         REG_MERGE_GAP:     csr_prdata = CSR_DATA_BITS'(gap_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // The entry count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("entry count above table size");

   // A clear result always reports an empty table.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.status == ST_CLEARED) |-> rsp_item_ff.used == '0)
      else $error("clear result reports entries");

   // Only a dump gives more than one result per item.
   a_last_only_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.last |-> rsp_item_ff.status == ST_ENTRY)
      else $error("non-final result outside a dump");

   // A forced merge happens only on a full table.
   a_forced_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.status == ST_FORCED)
      |-> rsp_item_ff.used == USED_BITS'(MAX_ENTRIES))
      else $error("forced merge with room left");

   // An append grows the count by exactly one.
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      emit && (emit_item.status == ST_APPENDED)
      |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("append did not grow the table by one");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dirty_rect_merge_table_core: clear, add, dump and ignored
// items with random idling on both streams, checked against a shadow of the rectangle table.
// Depends on dmt_pkg and the RTL under design/; reads no files.

module tb;
   import dmt_pkg::*;

   // Operation code 3 has no name in the package; the block must ignore it.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int LIMIT_CYCLES   = 400000;
   localparam int SETTLE_CYCLES  = 64;   // covers the longest item, a forced merge on a full table
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PER_SET = 22;

   // Shadow of the rectangle table. Every accepted item is replayed here and the
   // result items it must cause are queued in order; every result item leaving the
   // block is compared against the head of that queue.
   class dirty_table_shadow;
      int           ent_x1[MAX_ENTRIES];
      int           ent_y1[MAX_ENTRIES];
      int           ent_x2[MAX_ENTRIES];
      int           ent_y2[MAX_ENTRIES];
      int           used;
      int           width_reg;
      int           height_reg;
      int           gap_reg;
      rsp_item_type pending_reports[$];
      int           failures;
      int           checked;
      int           status_seen[8];

      function new();
         used       = 0;
         width_reg  = int'(SCREEN_WIDTH_RESET);
         height_reg = int'(SCREEN_HEIGHT_RESET);
         gap_reg    = int'(MERGE_GAP_RESET);
         failures   = 0;
         checked    = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         foreach (ent_x1[i]) begin
            ent_x1[i] = 0;
            ent_y1[i] = 0;
            ent_x2[i] = 0;
            ent_y2[i] = 0;
         end
      endfunction

      function void write_register(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_SCREEN_WIDTH:  width_reg  = int'(value[DIM_BITS-1:0]);
            REG_SCREEN_HEIGHT: height_reg = int'(value[DIM_BITS-1:0]);
            REG_MERGE_GAP:     gap_reg    = int'(value[GAP_BITS-1:0]);
            default: ;
         endcase
      endfunction

      function int register_value(reg_index_type idx);
         case (idx)
            REG_SCREEN_WIDTH:  return width_reg;
            REG_SCREEN_HEIGHT: return height_reg;
            default:           return gap_reg;
         endcase
      endfunction

      // Largest coordinate a screen dimension allows: 0 acts as 1, and anything
      // beyond the coordinate range acts as the full range.
      function int last_coord(int dim);
         if (dim < 1) return 0;
         if (dim > (1 << COORD_BITS)) return (1 << COORD_BITS) - 1;
         return dim - 1;
      endfunction

      function int clamp(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // Clamp to the screen, then widen the x span to whole 4-pixel groups.
      function void clip_to_screen(inout int x1, inout int y1, inout int x2, inout int y2);
         int wm;
         int hm;
         wm = last_coord(width_reg);
         hm = last_coord(height_reg);
         x1 = clamp(x1, 0, wm);
         y1 = clamp(y1, 0, hm);
         x2 = clamp(x2, 0, wm);
         y2 = clamp(y2, 0, hm);
         x1 = x1 & ~3;
         x2 = clamp((x2 & ~3) + 3, 0, wm);
      endfunction

      function bit is_near(int k, int x1, int y1, int x2, int y2);
         return ent_x1[k] <= x2 + gap_reg && ent_x2[k] + gap_reg >= x1 &&
                ent_y1[k] <= y2 + gap_reg && ent_y2[k] + gap_reg >= y1;
      endfunction

      // Grow entry k to the bounding box of itself and the new rectangle, then clip.
      function void merge_into(int k, int x1, int y1, int x2, int y2);
         int bx1;
         int by1;
         int bx2;
         int by2;
         bx1 = (x1 < ent_x1[k]) ? x1 : ent_x1[k];
         by1 = (y1 < ent_y1[k]) ? y1 : ent_y1[k];
         bx2 = (x2 > ent_x2[k]) ? x2 : ent_x2[k];
         by2 = (y2 > ent_y2[k]) ? y2 : ent_y2[k];
         clip_to_screen(bx1, by1, bx2, by2);
         ent_x1[k] = bx1;
         ent_y1[k] = by1;
         ent_x2[k] = bx2;
         ent_y2[k] = by2;
      endfunction

      function void queue_report(status_type st, int k, bit with_rect, bit last);
         rsp_item_type r;
         r = '0;
         r.status = st;
         r.index  = INDEX_BITS'(k);
         if (with_rect) begin
            r.rect.x1 = COORD_BITS'(ent_x1[k]);
            r.rect.y1 = COORD_BITS'(ent_y1[k]);
            r.rect.x2 = COORD_BITS'(ent_x2[k]);
            r.rect.y2 = COORD_BITS'(ent_y2[k]);
         end
         r.used = USED_BITS'(used);
         r.last = last;
         pending_reports.push_back(r);
      endfunction

      function void note_command(logic [OP_BITS-1:0] op, logic [REQ_DATA_BITS-1:0] data);
         int  x1;
         int  y1;
         int  x2;
         int  y2;
         int  k;
         int  best;
         int  best_px;
         int  px;
         bit  done;
         if (op == OP_CLEAR) begin
            used = 0;
            queue_report(ST_CLEARED, 0, 1'b0, 1'b1);
         end else if (op == OP_DUMP) begin
            if (used == 0) begin
               queue_report(ST_EMPTY, 0, 1'b0, 1'b1);
            end else begin
               for (k = 0; k < used; k++) queue_report(ST_ENTRY, k, 1'b1, k == used - 1);
            end
         end else if (op == OP_ADD) begin
            x1 = int'($signed(data[IN_BITS-1:0]));
            y1 = int'($signed(data[2*IN_BITS-1:IN_BITS]));
            x2 = int'($signed(data[3*IN_BITS-1:2*IN_BITS]));
            y2 = int'($signed(data[4*IN_BITS-1:3*IN_BITS]));
            if (x1 > x2 || y1 > y2) begin
               queue_report(ST_REJECTED, 0, 1'b0, 1'b1);
            end else begin
               clip_to_screen(x1, y1, x2, y2);
               done = 1'b0;
               // The first entry within the merge distance takes the rectangle.
               for (k = 0; k < used && !done; k++) begin
                  if (is_near(k, x1, y1, x2, y2)) begin
                     merge_into(k, x1, y1, x2, y2);
                     queue_report(ST_MERGED, k, 1'b1, 1'b1);
                     done = 1'b1;
                  end
               end
               if (!done && used < MAX_ENTRIES) begin
                  ent_x1[used] = x1;
                  ent_y1[used] = y1;
                  ent_x2[used] = x2;
                  ent_y2[used] = y2;
                  used++;
                  queue_report(ST_APPENDED, used - 1, 1'b1, 1'b1);
               end else if (!done) begin
                  // Full table: the smallest entry absorbs it, lowest index on a tie.
                  best    = 0;
                  best_px = 32'h7fff_ffff;
                  for (k = 0; k < MAX_ENTRIES; k++) begin
                     px = (ent_x2[k] - ent_x1[k] + 1) * (ent_y2[k] - ent_y1[k] + 1);
                     if (px < best_px) begin
                        best_px = px;
                        best    = k;
                     end
                  end
                  merge_into(best, x1, y1, x2, y2);
                  queue_report(ST_FORCED, best, 1'b1, 1'b1);
               end
            end
         end
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("tb: MISMATCH %s", msg);
      endfunction

      function void check_report(logic [STATUS_BITS-1:0] status,
                                 logic [RSP_DATA_BITS-1:0] data, logic last);
         rsp_item_type want;
         rsp_item_type got;
         // tdata from bit 0 up: entry_index, out_x1, out_y1, out_x2, out_y2, entries_used.
         got.status  = status_type'(status);
         got.index   = data[2:0];
         got.rect.x1 = data[12:3];
         got.rect.y1 = data[22:13];
         got.rect.x2 = data[32:23];
         got.rect.y2 = data[42:33];
         got.used    = data[46:43];
         got.last    = last;
         if (pending_reports.size() == 0) begin
            note_failure($sformatf("unexpected result: status %0d index %0d (%0d,%0d)-(%0d,%0d)",
                                   got.status, got.index, got.rect.x1, got.rect.y1,
                                   got.rect.x2, got.rect.y2));
            return;
         end
         want = pending_reports.pop_front();
         checked++;
         status_seen[want.status]++;
         if (got.status != want.status || got.index != want.index ||
             got.rect.x1 != want.rect.x1 || got.rect.y1 != want.rect.y1 ||
             got.rect.x2 != want.rect.x2 || got.rect.y2 != want.rect.y2 ||
             got.used != want.used || got.last != want.last) begin
            note_failure($sformatf(
               "result %0d: expected st %0d idx %0d (%0d,%0d)-(%0d,%0d) used %0d last %0d, got st %0d idx %0d (%0d,%0d)-(%0d,%0d) used %0d last %0d",
               checked, want.status, want.index, want.rect.x1, want.rect.y1, want.rect.x2,
               want.rect.y2, want.used, want.last, got.status, got.index, got.rect.x1,
               got.rect.y1, got.rect.x2, got.rect.y2, got.used, got.last));
         end
      endfunction
   endclass

   // Every input starts at a known value.
   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata   = '0;
   logic [OP_BITS-1:0]         req_tuser   = OP_CLEAR;
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   logic [STATUS_BITS-1:0]     rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   dirty_table_shadow shadow;
   int                cycle_count = 0;
   int                items_sent  = 0;
   int                settings    = 1;
   bit                calm        = 1'b0;  // while set, neither side idles

   dirty_rect_merge_table_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // in_x1, in_y1, in_x2, in_y2
      .req_tuser   (req_tuser),    // operation
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // entry_index, out_x1, out_y1, out_x2, out_y2, entries_used
      .rsp_tuser   (rsp_tuser),    // status
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // The run is bounded; a hang anywhere ends it as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // Both streams are observed at the clock edge, before any update of that edge
   // lands, so the shadow sees exactly the items the block accepted and emitted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) shadow.check_report(rsp_tuser, rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) shadow.note_command(req_tuser, req_tdata);
      end
   end

   // Result side: before each item it may hold tready low for a random stall.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Input side: an optional gap, then tvalid is held until the block takes the item.
   // With no gap, tvalid simply stays high across back-to-back items.
   task automatic send_item(logic [OP_BITS-1:0] op, logic [REQ_DATA_BITS-1:0] data);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic send_add(int x1, int y1, int x2, int y2);
      send_item(OP_ADD, {IN_BITS'(y2), IN_BITS'(x2), IN_BITS'(y1), IN_BITS'(x1)});
   endtask

   // One APB transfer: setup cycle, then access cycle until pready.
   task automatic csr_access(input bit is_write, input reg_index_type idx,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic verify_register(reg_index_type idx);
      logic [CSR_DATA_BITS-1:0] got;
      csr_access(1'b0, idx, '0, got);
      if (got != CSR_DATA_BITS'(shadow.register_value(idx))) begin
         shadow.note_failure($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                                       idx, got, shadow.register_value(idx)));
      end
   endtask

   // Unused upper bits of the write data carry noise; only the field width counts.
   task automatic set_register(reg_index_type idx, int value);
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [CSR_DATA_BITS-1:0] unused_rd;
      wdata = ($urandom() & ~32'h7ff) | (value & 32'h7ff);
      if (idx == REG_MERGE_GAP) wdata = ($urandom() & ~32'hff) | (value & 32'hff);
      csr_access(1'b1, idx, wdata, unused_rd);
      shadow.write_register(idx, wdata);
      verify_register(idx);
   endtask

   // Lets every queued result drain, then waits SETTLE_CYCLES more as a margin.
   task automatic wait_idle();
      @(posedge clock);
      while (shadow.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed adds sized to the current screen, so the table fills,
   // merges and overflows; the rest are raw field values, clears, dumps and
   // the ignored opcode.
   task automatic send_random_item();
      int                       pick;
      int                       w;
      int                       h;
      int                       x1;
      int                       y1;
      int                       x2;
      int                       y2;
      logic [REQ_DATA_BITS-1:0] noise;
      noise = REQ_DATA_BITS'({$urandom(), $urandom()});
      pick  = $urandom_range(0, 99);
      if (pick < 6) begin
         send_item(OP_CLEAR, noise);
      end else if (pick < 20) begin
         send_item(OP_DUMP, noise);
      end else if (pick < 25) begin
         send_item(OP_UNUSED, noise);
      end else if (pick < 37) begin
         send_item(OP_ADD, noise);
      end else begin
         w  = shadow.last_coord(shadow.width_reg) + 1;
         h  = shadow.last_coord(shadow.height_reg) + 1;
         x1 = $urandom_range(0, w + 31) - 16;
         y1 = $urandom_range(0, h + 31) - 16;
         x2 = x1 + (($urandom_range(0, 4) == 0) ? $urandom_range(0, w) : $urandom_range(0, 24));
         y2 = y1 + (($urandom_range(0, 4) == 0) ? $urandom_range(0, h) : $urandom_range(0, 24));
         if ($urandom_range(0, 19) == 0) begin
            // Inverted corners: rejected as empty.
            send_add(x2 + 1, y1, x1, y2);
         end else begin
            send_add(x1, y1, x2, y2);
         end
      end
   endtask

   task automatic run_random(int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         if (($urandom_range(0, 9)) == 0) calm = ($urandom_range(0, 2) == 0);
         send_random_item();
      end
      calm = 1'b0;
   endtask

   initial begin
      int k;
      shadow = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values of all three registers.
      verify_register(REG_SCREEN_WIDTH);
      verify_register(REG_SCREEN_HEIGHT);
      verify_register(REG_MERGE_GAP);

      // Directed part on the reset screen (412 x 412, merge distance 8).
      send_item(OP_DUMP, '0);                     // dump of an empty table
      send_item(OP_CLEAR, '1);
      send_add(5, 10, 4, 20);                     // x1 > x2: rejected
      send_add(5, 10, 6, 9);                      // y1 > y2: rejected
      send_add(-2048, -2048, 2047, 2047);         // field extremes clamp to full screen
      send_add(2000, 1500, 2047, 2047);           // off screen: clamps to the corner
      send_item(OP_DUMP, '1);
      send_item(OP_CLEAR, '0);
      // Eight small entries, far apart and of equal size.
      for (k = 0; k < MAX_ENTRIES; k++) begin
         send_add((k % 4) * 100, (k / 4) * 200, (k % 4) * 100 + 3, (k / 4) * 200 + 1);
      end
      send_add(380, 380, 390, 390);               // full table: tie goes to entry 0
      send_add(306, 4, 310, 6);                   // close to an existing entry: merge
      send_item(OP_UNUSED, REQ_DATA_BITS'({$urandom(), $urandom()}));
      send_item(OP_DUMP, '0);
      send_item(OP_CLEAR, '0);
      send_add(-2048, -2048, -1, -1);             // entirely left of and above the screen
      send_item(OP_DUMP, '0);
      run_random(RANDOM_PER_SET);
      req_tvalid <= 1'b0;

      // Further settings, each applied with the block idle and the table kept, so
      // older entries meet new screen bounds: largest screen with no merge distance,
      // the smallest screen with the largest distance, out-of-range sizes, random.
      for (k = 1; k <= 6; k++) begin
         wait_idle();
         case (k)
            1: begin
               set_register(REG_SCREEN_WIDTH, 1024);
               set_register(REG_SCREEN_HEIGHT, 1024);
               set_register(REG_MERGE_GAP, 0);
            end
            2: begin
               set_register(REG_SCREEN_WIDTH, 1);
               set_register(REG_SCREEN_HEIGHT, 1);
               set_register(REG_MERGE_GAP, 255);
            end
            3: begin
               set_register(REG_SCREEN_WIDTH, 0);
               set_register(REG_SCREEN_HEIGHT, 2047);
               set_register(REG_MERGE_GAP, 3);
            end
            4: begin
               set_register(REG_SCREEN_WIDTH, 1025);
               set_register(REG_SCREEN_HEIGHT, 0);
               set_register(REG_MERGE_GAP, 255);
            end
            default: begin
               set_register(REG_SCREEN_WIDTH, $urandom_range(1, 1024));
               set_register(REG_SCREEN_HEIGHT, $urandom_range(1, 1024));
               set_register(REG_MERGE_GAP, $urandom_range(0, 255));
            end
         endcase
         settings++;
         run_random(RANDOM_PER_SET);
         req_tvalid <= 1'b0;
      end

      wait_idle();
      if (shadow.pending_reports.size() != 0) begin
         shadow.note_failure($sformatf("%0d results never arrived",
                                       shadow.pending_reports.size()));
      end

      $display("tb: %0d items under %0d register settings, %0d results compared",
               items_sent, settings, shadow.checked);
      $display("tb: appended %0d, merged %0d, forced %0d, rejected %0d, dumped %0d, mismatches %0d",
               shadow.status_seen[ST_APPENDED], shadow.status_seen[ST_MERGED],
               shadow.status_seen[ST_FORCED], shadow.status_seen[ST_REJECTED],
               shadow.status_seen[ST_ENTRY], shadow.failures);
      if (shadow.failures == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
